// ===== rtl/core/tracked_object_dwell_detector_defines.svh =====
// Assertion macros shared by the dwell detector RTL.
`ifndef TRACKED_OBJECT_DWELL_DETECTOR_DEFINES_SVH
`define TRACKED_OBJECT_DWELL_DETECTOR_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define TDD_ASSERT_NOW(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define TDD_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TDD_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/tdd_pkg.sv =====
// Types, constants and codes shared by the dwell detector modules.
package tdd_pkg;

	localparam int TABLE_ENTRIES_DEF = 16;

	localparam int ID_W       = 16;
	localparam int VEL_W      = 16;
	localparam int STAMP_W    = 32;
	localparam int THR_W      = 16;
	localparam int DWELL_W    = 32;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 1;
	localparam int SQ_W       = 32;

	localparam logic [THR_W-1:0]   THR_RESET   = 16'd26;
	localparam logic [DWELL_W-1:0] DWELL_RESET = 32'd2000;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SPEED_THR = 1'b0,
		REG_DWELL     = 1'b1
	} cfg_reg_t;

	// Operand chosen for the shared squaring multiplier.
	typedef enum logic [1:0] {
		MS_X   = 2'd0,
		MS_Y   = 2'd1,
		MS_Z   = 2'd2,
		MS_THR = 2'd3
	} mul_sel_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_SPD,
		S_SCAN,
		S_UPD,
		S_END
	} state_t;

	// One table entry: object identity and first-seen stamp.
	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [STAMP_W-1:0] since;
	} ent_t;

	typedef struct packed {
		logic     load;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     acc_clr;
		logic     acc_add;
		logic     scan_clr;
		logic     rd_en;
		logic     upd_en;
		logic     frame_end;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic last;
		logic fast;
		logic scan_done;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/core/tdd_ctrl.sv =====
// Controller state machine that sequences one word through the datapath.
module tdd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  tdd_pkg::sts_t   sts,
	output tdd_pkg::cmd_t   cmd
);

	tdd_pkg::state_t   state_q, state_d;
	tdd_pkg::mul_sel_t step_q, step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tdd_pkg::S_IDLE;
			step_q  <= tdd_pkg::MS_X;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		step_d    = step_q;
		cmd       = '0;
		cmd.mul_sel = step_q;
		in_stall  = (state_q != tdd_pkg::S_IDLE);
		unique case (state_q)
			tdd_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					step_d   = tdd_pkg::MS_X;
					state_d  = tdd_pkg::S_MUL;
				end
			end
			tdd_pkg::S_MUL: begin
				if (sts.empty) begin
					state_d = tdd_pkg::S_END;
				end else begin
					cmd.mul_en  = 1'b1;
					cmd.acc_clr = (step_q == tdd_pkg::MS_X);
					cmd.acc_add = (step_q != tdd_pkg::MS_X);
					unique case (step_q)
						tdd_pkg::MS_X:   step_d = tdd_pkg::MS_Y;
						tdd_pkg::MS_Y:   step_d = tdd_pkg::MS_Z;
						tdd_pkg::MS_Z:   step_d = tdd_pkg::MS_THR;
						tdd_pkg::MS_THR: state_d = tdd_pkg::S_SPD;
						default:         state_d = tdd_pkg::S_SPD;
					endcase
				end
			end
			tdd_pkg::S_SPD: begin
				if (sts.fast) begin
					state_d = sts.last ? tdd_pkg::S_END : tdd_pkg::S_IDLE;
				end else begin
					cmd.scan_clr = 1'b1;
					state_d      = tdd_pkg::S_SCAN;
				end
			end
			tdd_pkg::S_SCAN: begin
				if (!sts.scan_done) begin
					cmd.rd_en = 1'b1;
				end else begin
					state_d = tdd_pkg::S_UPD;
				end
			end
			tdd_pkg::S_UPD: begin
				cmd.upd_en = 1'b1;
				state_d    = sts.last ? tdd_pkg::S_END : tdd_pkg::S_IDLE;
			end
			tdd_pkg::S_END: begin
				if (sts.out_free) begin
					cmd.frame_end = 1'b1;
					state_d       = tdd_pkg::S_IDLE;
				end
			end
			default: state_d = tdd_pkg::S_IDLE;
		endcase
	end

endmodule

// ===== rtl/core/tdd_dpath.sv =====
// Datapath: input capture, speed squaring, ping-pong object tables and result register.
`include "tracked_object_dwell_detector_defines.svh"

module tdd_dpath #(
	parameter int TABLE_ENTRIES = tdd_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tdd_pkg::cmd_t                    cmd,
	output tdd_pkg::sts_t                    sts,
	input  logic                             kind,
	input  logic [tdd_pkg::ID_W-1:0]         object_id,
	input  logic signed [tdd_pkg::VEL_W-1:0] vel_x,
	input  logic signed [tdd_pkg::VEL_W-1:0] vel_y,
	input  logic signed [tdd_pkg::VEL_W-1:0] vel_z,
	input  logic [tdd_pkg::STAMP_W-1:0]      frame_stamp,
	input  logic                             last_in_frame,
	input  logic                             cfg_valid,
	input  logic [tdd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tdd_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             stopped,
	output logic                             table_overflow
);

	localparam int CW        = $clog2(TABLE_ENTRIES + 1);
	localparam int IW        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int AW        = IW + 1;
	localparam int MEM_DEPTH = 1 << AW;
	localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_ENTRIES);

	// Captured word.
	logic                             kind_q;
	logic                             last_q;
	logic [tdd_pkg::ID_W-1:0]         id_q;
	logic signed [tdd_pkg::VEL_W-1:0] vx_q, vy_q, vz_q;
	logic [tdd_pkg::STAMP_W-1:0]      stamp_q;

	// Configuration.
	logic [tdd_pkg::THR_W-1:0]   thr_q;
	logic [tdd_pkg::DWELL_W-1:0] dwell_q;

	// Squaring unit.
	logic signed [tdd_pkg::VEL_W:0]     mul_op;
	logic signed [2*tdd_pkg::VEL_W+1:0] mul_full;
	logic [tdd_pkg::SQ_W-1:0]           prod_q;
	logic [tdd_pkg::SQ_W-1:0]           acc_q;

	// Tables: two banks in one memory, bank_q selects the previous frame's bank.
	tdd_pkg::ent_t  mem_q [MEM_DEPTH];
	logic           bank_q;
	logic [CW-1:0]  old_cnt_q, new_cnt_q;
	logic [CW-1:0]  idx_q;
	logic [CW-1:0]  scan_lim;
	logic [CW-1:0]  idx_s1;
	logic           rd_vld_s1;
	tdd_pkg::ent_t  rda_s1, rdb_s1;
	logic [AW-1:0]  addr_old, addr_new, addr_wr;

	// Scan results.
	logic                        found_q, dup_q;
	logic [tdd_pkg::STAMP_W-1:0] since_q;
	logic                        old_hit, new_hit;

	logic                        verdict_q, ovf_q;
	logic [tdd_pkg::STAMP_W-1:0] dwell_d;
	logic                        out_valid_q, stopped_q, ovf_out_q;

	always_comb begin
		case (cmd.mul_sel)
			tdd_pkg::MS_X:   mul_op = {vx_q[tdd_pkg::VEL_W-1], vx_q};
			tdd_pkg::MS_Y:   mul_op = {vy_q[tdd_pkg::VEL_W-1], vy_q};
			tdd_pkg::MS_Z:   mul_op = {vz_q[tdd_pkg::VEL_W-1], vz_q};
			default:         mul_op = {1'b0, thr_q};
		endcase
	end

	assign mul_full = mul_op * mul_op;

	assign scan_lim = (old_cnt_q > new_cnt_q) ? old_cnt_q : new_cnt_q;
	assign addr_old = {bank_q, idx_q[IW-1:0]};
	assign addr_new = {~bank_q, idx_q[IW-1:0]};
	assign addr_wr  = {~bank_q, new_cnt_q[IW-1:0]};

	assign old_hit = rd_vld_s1 && (idx_s1 < old_cnt_q) && (rda_s1.id == id_q);
	assign new_hit = rd_vld_s1 && (idx_s1 < new_cnt_q) && (rdb_s1.id == id_q);
	assign dwell_d = stamp_q - since_q;

	always_comb begin
		sts.empty     = kind_q;
		sts.last      = last_q;
		sts.fast      = (acc_q > prod_q);
		sts.scan_done = (idx_q >= scan_lim);
		sts.out_free  = !out_valid_q || !out_stall;
	end

	// Control state and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= tdd_pkg::THR_RESET;
			dwell_q     <= tdd_pkg::DWELL_RESET;
			bank_q      <= 1'b0;
			old_cnt_q   <= '0;
			new_cnt_q   <= '0;
			idx_q       <= '0;
			rd_vld_s1   <= 1'b0;
			found_q     <= 1'b0;
			dup_q       <= 1'b0;
			verdict_q   <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (tdd_pkg::cfg_reg_t'(cfg_index))
					tdd_pkg::REG_SPEED_THR: thr_q   <= cfg_data[tdd_pkg::THR_W-1:0];
					tdd_pkg::REG_DWELL:     dwell_q <= cfg_data[tdd_pkg::DWELL_W-1:0];
					default: ;
				endcase
			end

			rd_vld_s1 <= cmd.rd_en;
			if (cmd.scan_clr) begin
				idx_q   <= '0;
				found_q <= 1'b0;
				dup_q   <= 1'b0;
			end else begin
				if (cmd.rd_en) begin
					idx_q <= idx_q + 1'b1;
				end
				if (old_hit) begin
					found_q <= 1'b1;
				end
				if (new_hit) begin
					dup_q <= 1'b1;
				end
			end

			if (cmd.upd_en) begin
				if (found_q && (dwell_d > dwell_q)) begin
					verdict_q <= 1'b1;
				end
				if (!dup_q) begin
					if (new_cnt_q < FULL_CNT) begin
						new_cnt_q <= new_cnt_q + 1'b1;
					end else begin
						ovf_q <= 1'b1;
					end
				end
			end

			if (cmd.frame_end) begin
				out_valid_q <= 1'b1;
				bank_q      <= ~bank_q;
				old_cnt_q   <= new_cnt_q;
				new_cnt_q   <= '0;
				verdict_q   <= 1'b0;
				ovf_q       <= 1'b0;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers and table memory.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= kind;
			last_q  <= last_in_frame;
			id_q    <= object_id;
			vx_q    <= vel_x;
			vy_q    <= vel_y;
			vz_q    <= vel_z;
			stamp_q <= frame_stamp;
		end
		if (cmd.mul_en) begin
			prod_q <= mul_full[tdd_pkg::SQ_W-1:0];
		end
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + prod_q;
		end
		if (cmd.rd_en) begin
			rda_s1 <= mem_q[addr_old];
			rdb_s1 <= mem_q[addr_new];
			idx_s1 <= idx_q;
		end
		// Only the first match in the previous table supplies the first-seen stamp.
		if (old_hit && !found_q && !cmd.scan_clr) begin
			since_q <= rda_s1.since;
		end
		if (cmd.upd_en && !dup_q && (new_cnt_q < FULL_CNT)) begin
			mem_q[addr_wr] <= '{id: id_q, since: (found_q ? since_q : stamp_q)};
		end
		if (cmd.frame_end) begin
			stopped_q <= verdict_q;
			ovf_out_q <= ovf_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign stopped        = stopped_q;
	assign table_overflow = ovf_out_q;

	`TDD_ASSERT_NOW(a_new_cnt_bound, new_cnt_q <= FULL_CNT, "new table count above capacity")
	`TDD_ASSERT_IMP(a_no_overwrite, cmd.frame_end, !out_valid_q || !out_stall,
		"frame result would overwrite a waiting word")
	`TDD_ASSERT_NXT(a_swap, cmd.frame_end,
		(new_cnt_q == '0) && out_valid_q && (old_cnt_q == $past(new_cnt_q)),
		"table swap at frame end went wrong")
	`TDD_ASSERT_NXT(a_grow, cmd.upd_en && !dup_q && (new_cnt_q < FULL_CNT),
		new_cnt_q == $past(new_cnt_q) + 1'b1, "slow object not entered in new table")

endmodule

// ===== rtl/core/tracked_object_dwell_detector.sv =====
// Top level of the tracked-object dwell detector.
//
//  Channel  Handshake              Payload
//  -------  ---------------------  ------------------------------------------------
//  input    in_valid / in_stall    kind, object_id, vel_x, vel_y, vel_z,
//                                  frame_stamp, last_in_frame
//  output   out_valid / out_stall  stopped, table_overflow
//  config   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One word is worked on at a time. A record is accepted, squares vel_x, vel_y, vel_z
// and the threshold in turn on the shared squaring multiplier, then compares speed; a
// slow record then scans both tables in parallel on the two memory read ports, up to
// max(previous count, current count) entries, and takes an update step. An empty word
// goes straight to the frame end. A frame end loads the result into its register.
// Reset empties both tables and clears the frame flags; no clearing pass is needed.
// A stalled result holds in its register while the next word is accepted; only a
// second frame end waits for it.
module tracked_object_dwell_detector #(
	parameter int TABLE_ENTRIES = tdd_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,

	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             kind,
	input  logic [tdd_pkg::ID_W-1:0]         object_id,
	input  logic signed [tdd_pkg::VEL_W-1:0] vel_x,
	input  logic signed [tdd_pkg::VEL_W-1:0] vel_y,
	input  logic signed [tdd_pkg::VEL_W-1:0] vel_z,
	input  logic [tdd_pkg::STAMP_W-1:0]      frame_stamp,
	input  logic                             last_in_frame,

	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             stopped,
	output logic                             table_overflow,

	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tdd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tdd_pkg::CFG_DATA_W-1:0]   cfg_data
);

	tdd_pkg::cmd_t cmd;
	tdd_pkg::sts_t sts;

	// Configuration registers are plain flops, so a write is always taken at once.
	assign cfg_ready = 1'b1;

	// The controller owns the sequence: capture, squaring steps, table scan, update
	// and frame end. It stalls the input side whenever it is not waiting for a word.
	tdd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the captured word, the squaring unit, the two table banks
	// that swap roles at every frame end, the frame flags and the result register.
	tdd_dpath #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.kind           (kind),
		.object_id      (object_id),
		.vel_x          (vel_x),
		.vel_y          (vel_y),
		.vel_z          (vel_z),
		.frame_stamp    (frame_stamp),
		.last_in_frame  (last_in_frame),
		.cfg_valid      (cfg_valid),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.stopped        (stopped),
		.table_overflow (table_overflow)
	);

endmodule
